### hdl/wildcard_anagram_window_matcher_core_macros.svh
// Assertion macros for the wildcard anagram window matcher.
// Depends on nothing; included by the top level only.
`ifndef WILDCARD_ANAGRAM_WINDOW_MATCHER_CORE_MACROS_SVH
`define WILDCARD_ANAGRAM_WINDOW_MATCHER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WAWM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wawm same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WAWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wawm next-cycle check failed");

`endif

### hdl/wawm_pkg.sv
// Shared types and constants for the wildcard anagram window matcher.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

package wawm_pkg;

   // Letters 0..ALPHABET-1; any symbol at or above ALPHABET is a wildcard.
   localparam int ALPHABET    = 26;
   localparam int SYM_W       = 5;
   localparam int CODE_W      = $clog2(ALPHABET + 1);
   localparam int MAX_PATTERN = 256;
   localparam int TOTAL_W     = 32;
   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_FIFO_AW    = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_FIFO_CW    = $clog2(RSP_FIFO_DEPTH + 3);
   localparam logic [CODE_W-1:0] WILDCARD_CODE = CODE_W'(ALPHABET);

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_PATTERN = 2'd1,
      OP_TEXT    = 2'd2
   } op_type;

endpackage

### hdl/wildcard_anagram_window_matcher_core.sv
// Wildcard anagram window matcher, top level.
// Each text beat that fills the window passes the stage-1 and stage-2 registers and
// is then written into the result queue, whose non-empty state drives rsp_tvalid.
// Throughput: one beat per cycle while req_tready is high; the three-stage pipe (ring
// pointer, histograms, match/total) never stalls; a 4-entry result queue absorbs stalls.
// Reset (synchronous, active high) empties histograms, counters and the queue;
// the history ring is not cleared, since only slots already written are used.
`timescale 1ns / 1ps

module wildcard_anagram_window_matcher_core #(
   parameter int MAX_PATTERN = wawm_pkg::MAX_PATTERN
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] symbol, [7:5] zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [0] window_matches, [32:1] match_total, [39:33] zero
);

   import wawm_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int RSP_W = TOTAL_W + 1;

   // ---------------------------------------------------------------
   // Stage 0: window bookkeeping at accept time
   // ---------------------------------------------------------------
   logic              req_beat;
   op_type            req_op;
   logic [SYM_W-1:0]  req_sym;
   logic [CODE_W-1:0] req_code;

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;

   logic [LEN_W-1:0]  ptr_eff;
   logic [LEN_W-1:0]  ptr_inc;
   logic              text_go;
   logic              win_full;
   logic              emit0;
   logic              go0;

   // stage 1 registers
   logic              s1_valid_ff, s1_valid_in;
   op_type            s1_op_ff, s1_op_in;
   logic [CODE_W-1:0] s1_code_ff;
   logic              s1_remove_ff, s1_remove_in;
   logic              s1_emit_ff, s1_emit_in;

   logic [CODE_W-1:0] old_code;

   assign req_beat = req_tvalid && req_tready;
   assign req_op   = op_type'(req_tuser);
   assign req_sym  = req_tdata[SYM_W-1:0];
   assign req_code = (req_sym < SYM_W'(ALPHABET)) ? CODE_W'(req_sym) : WILDCARD_CODE;

   // Wrap the pointer if it ever sits past the window end.
   assign ptr_eff  = (LEN_W'(ptr_ff) >= len_ff) ? '0 : LEN_W'(ptr_ff);
   assign ptr_inc  = ptr_eff + LEN_W'(1);
   assign win_full = (fill_ff >= len_ff);
   assign text_go  = req_beat && (req_op == OP_TEXT) && (len_ff != '0);

   always_comb begin
      len_in  = len_ff;
      fill_in = fill_ff;
      ptr_in  = ptr_ff;
      go0     = 1'b0;
      emit0   = 1'b0;
      if (req_beat) begin
         unique case (req_op)
            OP_CLEAR: begin
               len_in  = '0;
               fill_in = '0;
               ptr_in  = '0;
               go0     = 1'b1;
            end
            OP_PATTERN: begin
               if ((req_sym < SYM_W'(ALPHABET)) && (len_ff < LEN_W'(MAX_PATTERN))) begin
                  len_in  = len_ff + LEN_W'(1);
                  fill_in = '0;
                  ptr_in  = '0;
                  go0     = 1'b1;
               end
            end
            OP_TEXT: begin
               if (len_ff != '0) begin
                  // a full window drops its oldest symbol, so fill holds
                  fill_in = win_full ? fill_ff : fill_ff + LEN_W'(1);
                  ptr_in  = (ptr_inc >= len_ff) ? '0 : PTR_W'(ptr_inc);
                  go0     = 1'b1;
                  emit0   = (fill_in >= len_ff);
               end
            end
            default: begin
               go0 = 1'b0;
            end
         endcase
      end
   end

   assign s1_valid_in  = go0;
   assign s1_op_in     = req_op;
   assign s1_remove_in = text_go && win_full;
   assign s1_emit_in   = emit0;

   // History ring: read the oldest slot and overwrite it in the same beat.
   wawm_ram #(
      .WIDTH (CODE_W),
      .DEPTH (MAX_PATTERN),
      .AW    (PTR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (text_go),
      .wr_addr (PTR_W'(ptr_eff)),
      .wr_data (req_code),
      .rd_en   (text_go),
      .rd_addr (PTR_W'(ptr_eff)),
      .rd_data (old_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s1_remove_ff <= 1'b0;
         s1_emit_ff   <= 1'b0;
      end else begin
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         s1_valid_ff  <= s1_valid_in;
         s1_remove_ff <= s1_remove_in;
         s1_emit_ff   <= s1_emit_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff   <= s1_op_in;
      s1_code_ff <= req_code;
   end

   // ---------------------------------------------------------------
   // Stage 1: histogram update (at most two bins move per text beat)
   // ---------------------------------------------------------------
   logic [LEN_W-1:0] pat_hist_ff [ALPHABET];
   logic [LEN_W-1:0] pat_hist_in [ALPHABET];
   logic [LEN_W-1:0] win_hist_ff [ALPHABET];
   logic [LEN_W-1:0] win_hist_in [ALPHABET];

   logic s2_valid_ff, s2_valid_in;
   logic s2_clear_ff, s2_clear_in;

   always_comb begin
      logic add_bin;
      logic rem_bin;
      for (int j = 0; j < ALPHABET; j++) begin
         pat_hist_in[j] = pat_hist_ff[j];
         win_hist_in[j] = win_hist_ff[j];
         add_bin = 1'b0;
         rem_bin = 1'b0;
         if (s1_valid_ff) begin
            case (s1_op_ff)
               OP_CLEAR: begin
                  pat_hist_in[j] = '0;
                  win_hist_in[j] = '0;
               end
               OP_PATTERN: begin
                  if (s1_code_ff == CODE_W'(j)) begin
                     pat_hist_in[j] = pat_hist_ff[j] + LEN_W'(1);
                  end
                  win_hist_in[j] = '0;
               end
               OP_TEXT: begin
                  add_bin = (s1_code_ff == CODE_W'(j));
                  rem_bin = s1_remove_ff && (old_code == CODE_W'(j)) &&
                            (win_hist_ff[j] != '0);
                  case ({add_bin, rem_bin})
                     2'b10:   win_hist_in[j] = win_hist_ff[j] + LEN_W'(1);
                     2'b01:   win_hist_in[j] = win_hist_ff[j] - LEN_W'(1);
                     default: win_hist_in[j] = win_hist_ff[j];
                  endcase
               end
               default: begin
                  win_hist_in[j] = win_hist_ff[j];
               end
            endcase
         end
      end
   end

   assign s2_valid_in = s1_valid_ff && (s1_op_ff == OP_TEXT) && s1_emit_ff;
   assign s2_clear_in = s1_valid_ff && (s1_op_ff == OP_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ALPHABET; j++) begin
            pat_hist_ff[j] <= '0;
            win_hist_ff[j] <= '0;
         end
         s2_valid_ff <= 1'b0;
         s2_clear_ff <= 1'b0;
      end else begin
         for (int j = 0; j < ALPHABET; j++) begin
            pat_hist_ff[j] <= pat_hist_in[j];
            win_hist_ff[j] <= win_hist_in[j];
         end
         s2_valid_ff <= s2_valid_in;
         s2_clear_ff <= s2_clear_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: match test and saturating total. The histograms hold
   // exactly this beat's window here, since stage 1 wrote them last edge.
   // ---------------------------------------------------------------
   logic               match;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] total_next;

   always_comb begin
      match = 1'b1;
      for (int j = 0; j < ALPHABET; j++) begin
         if (win_hist_ff[j] > pat_hist_ff[j]) begin
            match = 1'b0;
         end
      end
   end

   assign total_next = (match && (total_ff != '1)) ? total_ff + TOTAL_W'(1) : total_ff;

   always_comb begin
      total_in = total_ff;
      if (s2_clear_ff) begin
         total_in = '0;
      end else if (s2_valid_ff) begin
         total_in = total_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   // ---------------------------------------------------------------
   // Result queue: credit-checked so the pipe never has to stall
   // ---------------------------------------------------------------
   logic [RSP_W-1:0]          fifo_mem_ff [RSP_FIFO_DEPTH];
   logic [RSP_FIFO_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [RSP_FIFO_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [RSP_FIFO_CW-1:0]    count_ff, count_in;
   logic [RSP_FIFO_CW-1:0]    pending;
   logic                      push;
   logic                      pop;

   assign push = s2_valid_ff;
   assign pop  = rsp_tvalid && rsp_tready;

   // count the beats still in flight toward the queue as already taken
   assign pending    = count_ff + RSP_FIFO_CW'(s1_emit_ff && s1_valid_ff) +
                       RSP_FIFO_CW'(s2_valid_ff);
   assign req_tready = (pending < RSP_FIFO_CW'(RSP_FIFO_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + RSP_FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + RSP_FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + RSP_FIFO_CW'(1);
         2'b01:   count_in = count_ff - RSP_FIFO_CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= {total_next, match};
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {{(40 - RSP_W){1'b0}}, fifo_mem_ff[rd_ptr_ff]};

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
`include "wildcard_anagram_window_matcher_core_macros.svh"

   `WAWM_ASSERT_NOW(a_fill_le_len, clock, reset, 1'b1, fill_ff <= len_ff)
   `WAWM_ASSERT_NOW(a_ptr_in_window, clock, reset, len_ff != '0, LEN_W'(ptr_ff) < len_ff)
   `WAWM_ASSERT_NOW(a_push_has_room, clock, reset, push, count_ff < RSP_FIFO_CW'(RSP_FIFO_DEPTH))
   `WAWM_ASSERT_NEXT(a_emit_reaches_s2, clock, reset, s1_valid_ff && s1_emit_ff, s2_valid_ff)

endmodule

### hdl/wawm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; read-first when both ports hit the same address.
`timescale 1ns / 1ps

module wawm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
